@@ rtl/ddo_pkg.sv @@
// ----------------------------------------------------------------------------
// ddo_pkg
// Types, constants and the arctangent table for the wheel odometry block.
// ----------------------------------------------------------------------------
package ddo_pkg;

  localparam int unsigned CordicIterDefault = 24;

  localparam logic [31:0] MptReset    = 32'd1839960;
  localparam logic [31:0] TptdReset   = 32'd1774813;
  localparam logic [15:0] RejectReset = 16'd20;
  localparam logic [15:0] DbandReset  = 16'd10;

  localparam logic [1:0] RegMpt    = 2'd0;
  localparam logic [1:0] RegTptd   = 2'd1;
  localparam logic [1:0] RegReject = 2'd2;
  localparam logic [1:0] RegDband  = 2'd3;

  localparam logic [63:0] SpeedScale = 64'd1000000;
  localparam logic [63:0] TurnScale  = 64'd6283185;
  localparam logic signed [34:0] CordicGain = 35'sd652032874;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_PREP  = 8'b0000_0010,
    S_CORD  = 8'b0000_0100,
    S_MULX  = 8'b0000_1000,
    S_MULY  = 8'b0001_0000,
    S_DIVL  = 8'b0010_0000,
    S_DIVA  = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_e;

  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] t;
    unique case (i)
      5'd0:  t = 32'd536870912;
      5'd1:  t = 32'd316933406;
      5'd2:  t = 32'd167458907;
      5'd3:  t = 32'd85004756;
      5'd4:  t = 32'd42667331;
      5'd5:  t = 32'd21354465;
      5'd6:  t = 32'd10679838;
      5'd7:  t = 32'd5340245;
      5'd8:  t = 32'd2670163;
      5'd9:  t = 32'd1335087;
      5'd10: t = 32'd667544;
      5'd11: t = 32'd333772;
      5'd12: t = 32'd166886;
      5'd13: t = 32'd83443;
      5'd14: t = 32'd41722;
      5'd15: t = 32'd20861;
      5'd16: t = 32'd10430;
      5'd17: t = 32'd5215;
      5'd18: t = 32'd2608;
      5'd19: t = 32'd1304;
      5'd20: t = 32'd652;
      5'd21: t = 32'd326;
      5'd22: t = 32'd163;
      5'd23: t = 32'd81;
      5'd24: t = 32'd41;
      5'd25: t = 32'd20;
      5'd26: t = 32'd10;
      5'd27: t = 32'd5;
      5'd28: t = 32'd3;
      5'd29: t = 32'd1;
      5'd30: t = 32'd1;
      default: t = 32'd0;
    endcase
    return t;
  endfunction

endpackage

@@ rtl/differential_drive_odometry.sv @@
// A priming transfer leaves the block ready again on the next cycle; later
// transfers pass through S_PREP, S_CORD, S_MULX, S_MULY, S_DIVL, S_DIVA and S_OUT
// before m_axis_tvalid rises. The block takes no new item until it is through
// with the last: s_axis_tready is low while busy, and a result still held in the
// output register stalls only the out step.
// Reset clears pose, previous counts, primed flag and registers to defaults.
// ----------------------------------------------------------------------------
// differential_drive_odometry
// Wheel odometry: tick deltas, deadband, CORDIC pose update and speeds.
// ----------------------------------------------------------------------------
module differential_drive_odometry
  import ddo_pkg::*;
#(
  parameter int unsigned CORDIC_ITERATIONS = CordicIterDefault
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [1:0]   cfg_index_i,
  input  logic [31:0]  cfg_data_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // left_count[31:0], right_count[63:32], elapsed_us[95:64]
  input  logic [95:0]  s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // pos_x, pos_y, heading, linear_speed, angular_speed (32 bits each)
  output logic [159:0] m_axis_tdata
);

  localparam int unsigned ItW = $clog2(CORDIC_ITERATIONS + 1);

  function automatic logic [31:0] sat_quot(input logic neg, input logic big,
                                           input logic [63:0] q);
    logic [31:0] r;
    if (neg) r = (big || q > 64'd2147483648) ? 32'h8000_0000 : 32'(-q);
    else     r = (big || q > 64'd2147483647) ? 32'h7fff_ffff : 32'(q);
    return r;
  endfunction

  state_e state_q, state_d;
  logic [31:0] mpt_q, tptd_q;
  logic [15:0] rej_q, dband_q;
  logic        primed_q;
  logic [31:0] prev_l_q, prev_r_q;
  logic signed [31:0] posx_q, posy_q;
  logic [31:0] head_q;
  logic [31:0] elapsed_q;
  logic signed [63:0] dc_q, dth_q;
  logic signed [34:0] cx_q, cy_q, cz_q;
  logic        flip_q;
  logic [ItW-1:0] it_q;
  logic [6:0]  bit_q;
  logic [127:0] num_q;
  logic [63:0]  rem_q, q_q, den_q;
  logic         big_q, neg_q;
  logic [31:0]  lin_q;
  logic [159:0] out_q;
  logic         ovalid_q;

  logic s_fire;
  logic out_go;
  assign s_fire = s_axis_tvalid && s_axis_tready;
  assign out_go = (state_q == S_OUT) && (!ovalid_q || m_axis_tready);
  assign s_axis_tready = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata = out_q;

  logic [31:0] in_l, in_r, in_e;
  assign in_l = s_axis_tdata[31:0];
  assign in_r = s_axis_tdata[63:32];
  assign in_e = s_axis_tdata[95:64];

  logic signed [32:0] dl_raw, dr_raw, dl, dr, dsum, ddif;
  logic [32:0] mag_l, mag_r, mag_d;
  always_comb begin
    dl_raw = 33'(signed'(32'(in_l - prev_l_q)));
    dr_raw = 33'(signed'(32'(in_r - prev_r_q)));
    mag_l = dl_raw[32] ? 33'(-dl_raw) : 33'(dl_raw);
    mag_r = dr_raw[32] ? 33'(-dr_raw) : 33'(dr_raw);
    dl = (mag_l < {17'd0, dband_q}) ? '0 : dl_raw;
    dr = (mag_r < {17'd0, dband_q}) ? '0 : dr_raw;
    dsum = dl + dr;
    ddif = dr - dl;
    mag_d = ddif[32] ? 33'(-ddif) : 33'(ddif);
  end

  logic signed [63:0] dc_n, dth_n;
  logic signed [63:0] p_hi, p_lo;
  always_comb begin
    p_hi = 64'(dsum) * $signed({1'b0, 16'(mpt_q[31:16])});
    p_lo = 64'(dsum) * $signed({1'b0, 16'(mpt_q[15:0])});
    dc_n = (p_hi + (p_lo >>> 16)) >>> 1;
    dth_n = (mag_d > {17'd0, rej_q}) ? '0 : 64'(ddif) * $signed({1'b0, tptd_q});
  end

  logic [31:0] mid_ang, mid_fold;
  logic        mid_flip;
  logic signed [32:0] mid_s;
  always_comb begin
    mid_ang = head_q + 32'(dth_q >>> 1);
    mid_s = 33'(signed'(mid_ang));
    mid_flip = (mid_s > 33'sd1073741824) || (mid_s < -33'sd1073741824);
    mid_fold = mid_flip ? mid_ang + 32'h8000_0000 : mid_ang;
  end

  logic signed [34:0] xs, ys, at;
  always_comb begin
    xs = cx_q >>> it_q;
    ys = cy_q >>> it_q;
    at = 35'(signed'({1'b0, atan_turn(5'(it_q))}));
  end

  logic signed [33:0] dcc;
  logic signed [34:0] cmul;
  logic signed [69:0] prod;
  logic signed [63:0] pstep;
  logic signed [33:0] psum;
  logic signed [31:0] psat;
  always_comb begin
    dcc = (dc_q > 64'sd4294967296) ? 34'sd4294967296 :
          (dc_q < -64'sd4294967296) ? -34'sd4294967296 : 34'(dc_q);
    cmul = (state_q == S_MULX) ? (flip_q ? -cx_q : cx_q) : (flip_q ? -cy_q : cy_q);
    prod = 70'(dcc) * 70'(cmul);
    pstep = 64'(prod >>> 30);
    psum = 34'(pstep) + 34'((state_q == S_MULX) ? posx_q : posy_q);
    if (pstep > 64'sd4294967295) psat = 32'sh7fff_ffff;
    else if (pstep < -64'sd4294967296) psat = 32'sh8000_0000;
    else if (psum > 34'sd2147483647) psat = 32'sh7fff_ffff;
    else if (psum < -34'sd2147483648) psat = 32'sh8000_0000;
    else psat = 32'(psum);
  end

  logic [63:0] div_r2, q_nx;
  logic        take, big_nx;
  logic [63:0] mag_a;
  logic [127:0] mag_w, mnum;
  logic [31:0] dsat, lsat;
  always_comb begin
    div_r2 = {rem_q[62:0], num_q[127]};
    take   = (div_r2 >= den_q) || rem_q[63];
    q_nx   = {q_q[62:0], take};
    big_nx = big_q || (q_q >= 64'h4000_0000_0000_0000);
    mag_a = (state_q == S_CORD && it_q == ItW'(CORDIC_ITERATIONS)) ?
            (dc_q[63] ? 64'(-dc_q) : 64'(dc_q)) :
            (dth_q[63] ? 64'(-dth_q) : 64'(dth_q));
    mag_w = 128'(mag_a);
    // 1000000 and 6283185 as sums of shifted terms
    if (state_q == S_CORD)
      mnum = (mag_w << 20) - (mag_w << 16) + (mag_w << 14) + (mag_w << 9) + (mag_w << 6);
    else
      mnum = (mag_w << 22) + (mag_w << 21) - (mag_w << 13) - (mag_w << 6) - (mag_w << 4)
             + mag_w;
    dsat = sat_quot(neg_q, big_q, q_q);
    lsat = sat_quot(neg_q, big_nx, q_nx);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (s_fire && primed_q) state_d = S_PREP;
      S_PREP: state_d = S_CORD;
      S_CORD: if (it_q == ItW'(CORDIC_ITERATIONS)) state_d = S_MULX;
      S_MULX: state_d = S_MULY;
      S_MULY: state_d = S_DIVL;
      S_DIVL: if (bit_q == 7'd0) state_d = S_DIVA;
      S_DIVA: if (bit_q == 7'd0) state_d = S_OUT;
      S_OUT:  if (out_go) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      mpt_q    <= MptReset;
      tptd_q   <= TptdReset;
      rej_q    <= RejectReset;
      dband_q  <= DbandReset;
      primed_q <= 1'b0;
      prev_l_q <= '0;
      prev_r_q <= '0;
      posx_q   <= '0;
      posy_q   <= '0;
      head_q   <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          RegMpt:    mpt_q   <= cfg_data_i;
          RegTptd:   tptd_q  <= cfg_data_i;
          RegReject: rej_q   <= cfg_data_i[15:0];
          RegDband:  dband_q <= cfg_data_i[15:0];
          default: ;
        endcase
      end
      if (s_fire) begin
        prev_l_q <= in_l;
        prev_r_q <= in_r;
        primed_q <= 1'b1;
      end
      if (state_q == S_MULX) posx_q <= psat;
      if (state_q == S_MULY) begin
        posy_q <= psat;
        head_q <= head_q + 32'(dth_q);
      end
      if (out_go) ovalid_q <= 1'b1;
      else if (m_axis_tready) ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      dc_q <= dc_n;
      dth_q <= dth_n;
      elapsed_q <= (in_e == '0) ? 32'd1 : in_e;
    end
    if (state_q == S_PREP) begin
      cx_q <= CordicGain;
      cy_q <= '0;
      cz_q <= 35'(signed'(mid_fold));
      flip_q <= mid_flip;
      it_q <= '0;
    end
    if (state_q == S_CORD) begin
      if (it_q != ItW'(CORDIC_ITERATIONS)) begin
        if (!cz_q[34]) begin
          cx_q <= cx_q - ys; cy_q <= cy_q + xs; cz_q <= cz_q - at;
        end else begin
          cx_q <= cx_q + ys; cy_q <= cy_q - xs; cz_q <= cz_q + at;
        end
        it_q <= it_q + 1'b1;
      end else begin
        num_q <= mnum; rem_q <= '0; q_q <= '0; big_q <= 1'b0;
        neg_q <= dc_q[63]; den_q <= {32'd0, elapsed_q};
      end
    end
    if (state_q == S_MULY) bit_q <= 7'd127;
    if (state_q == S_DIVL || state_q == S_DIVA) begin
      if (state_q == S_DIVL && bit_q == 7'd0) begin
        lin_q <= lsat;
        num_q <= mnum; rem_q <= '0; q_q <= '0; big_q <= 1'b0;
        neg_q <= dth_q[63]; den_q <= {16'd0, elapsed_q, 16'd0};
        bit_q <= 7'd127;
      end else begin
        num_q <= {num_q[126:0], 1'b0};
        big_q <= big_nx;
        rem_q <= take ? div_r2 - den_q : div_r2;
        q_q   <= q_nx;
        bit_q <= bit_q - 1'b1;
      end
    end
    if (out_go) out_q <= {dsat, lin_q, head_q, posy_q, posx_q};
  end

  a_busy_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !s_axis_tready) else $error("ready while busy");
  a_out_after_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT) |=> m_axis_tvalid) else $error("result lost");
  a_prime_no_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_fire && !primed_q) |=> (state_q == S_IDLE)) else $error("primed item worked");

endmodule

@@ bench/differential_drive_odometry_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// differential_drive_odometry_tb
// Drives encoder readings through the odometry block and compares each pose
// and speed transfer with an in-bench fixed-point predictor of the block.
// ----------------------------------------------------------------------------
module differential_drive_odometry_tb;
  import ddo_pkg::*;

  localparam int unsigned StallLimit = 20000;
  localparam int unsigned Latency    = 300;

  typedef struct packed {
    logic [31:0] ang_spd;
    logic [31:0] lin_spd;
    logic [31:0] heading;
    logic [31:0] pos_y;
    logic [31:0] pos_x;
  } pose_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_valid_i = 1'b0;
  logic         cfg_ready_o;
  logic [1:0]   cfg_index_i = '0;
  logic [31:0]  cfg_data_i = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [95:0]  s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [159:0] m_axis_tdata;

  differential_drive_odometry dut (.*);

  always #4 clk_i = ~clk_i;

  // odometry state mirror
  logic [31:0] mpt, tptd;
  logic [15:0] reject_thr, dband;
  logic [31:0] prev_l, prev_r, head;
  logic        primed;
  logic signed [31:0] px, py;
  pose_t       pose_q[$];

  int unsigned errors = 0;
  int unsigned idle_cycles = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  bit          hold_off = 1'b0;

  function automatic longint floor_sh(longint v, int k);
    return v >>> k;
  endfunction

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic logic [31:0] scaled_quotient(longint a, logic [63:0] b, logic [63:0] d);
    logic [127:0] prod, q;
    logic [63:0]  mag;
    mag  = a < 0 ? 64'(-a) : 64'(a);
    prod = 128'(mag) * 128'(b);
    q    = prod / 128'(d);
    if (a < 0) begin
      if (q > 128'd2147483648) return 32'h8000_0000;
      return 32'(-q);
    end
    if (q > 128'd2147483647) return 32'h7fff_ffff;
    return q[31:0];
  endfunction

  function automatic void rotate(logic [31:0] ang, output longint c, output longint s);
    longint z, x, y, xs, ys;
    bit flip;
    z = longint'(signed'(ang));
    x = 652032874;
    y = 0;
    flip = 1'b0;
    if (z > 64'sd1073741824 || z < -64'sd1073741824) begin
      z = longint'(signed'(ang + 32'h8000_0000));
      flip = 1'b1;
    end
    for (int i = 0; i < CordicIterDefault; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys; y += xs; z -= longint'(atan_turn(5'(i)));
      end else begin
        x += ys; y -= xs; z += longint'(atan_turn(5'(i)));
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic longint apply_dband(longint d);
    longint m;
    m = d < 0 ? -d : d;
    return m < longint'(dband) ? 0 : d;
  endfunction

  function automatic void predict_pose(logic [95:0] rd);
    logic [31:0] l, r, el, mid;
    longint dl, dr, sum, diff, dc, dth, dcc, cs, sn, m;
    pose_t p;
    l  = rd[31:0];
    r  = rd[63:32];
    el = rd[95:64];
    if (!primed) begin
      prev_l = l; prev_r = r; primed = 1'b1;
      return;
    end
    if (el == 0) el = 1;
    dl = apply_dband(longint'(signed'(l - prev_l)));
    dr = apply_dband(longint'(signed'(r - prev_r)));
    prev_l = l; prev_r = r;
    sum  = dl + dr;
    diff = dr - dl;
    dc = floor_sh(sum * longint'(mpt[31:16]) + floor_sh(sum * longint'(mpt[15:0]), 16), 1);
    m  = diff < 0 ? -diff : diff;
    dth = m > longint'(reject_thr) ? 0 : diff * longint'(tptd);
    mid = head + 32'(floor_sh(dth, 1));
    rotate(mid, cs, sn);
    dcc = dc > 64'sd4294967296 ? 64'sd4294967296 :
          (dc < -64'sd4294967296 ? -64'sd4294967296 : dc);
    px = 32'(sat32(longint'(px) + floor_sh(dcc * cs, 30)));
    py = 32'(sat32(longint'(py) + floor_sh(dcc * sn, 30)));
    head += 32'(dth);
    p.pos_x   = px;
    p.pos_y   = py;
    p.heading = head;
    p.lin_spd = scaled_quotient(dc, SpeedScale, 64'(el));
    p.ang_spd = scaled_quotient(dth, TurnScale, 64'(el) << 16);
    pose_q.push_back(p);
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // result checker
  always @(posedge clk_i) begin
    pose_t g, e;
    if (m_axis_tvalid && m_axis_tready) begin
      g = m_axis_tdata;
      if (pose_q.size() == 0) begin
        report_mismatch("unexpected transfer", g.pos_x, '0);
      end else begin
        e = pose_q.pop_front();
        if (g.pos_x !== e.pos_x) report_mismatch("pos_x", g.pos_x, e.pos_x);
        if (g.pos_y !== e.pos_y) report_mismatch("pos_y", g.pos_y, e.pos_y);
        if (g.heading !== e.heading) report_mismatch("heading", g.heading, e.heading);
        if (g.lin_spd !== e.lin_spd) report_mismatch("linear_speed", g.lin_spd, e.lin_spd);
        if (g.ang_spd !== e.ang_spd) report_mismatch("angular_speed", g.ang_spd, e.ang_spd);
      end
    end
  end

  // receiver readiness
  always @(posedge clk_i) begin
    if (hold_off) m_axis_tready <= 1'b0;
    else m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > StallLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // tvalid stays high after a transfer until the next item or an idle cycle
  task automatic send_reading(logic [31:0] l, logic [31:0] r, logic [31:0] el);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {el, r, l};
    do @(posedge clk_i); while (!s_axis_tready);
    predict_pose({el, r, l});
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pose_q.size() != 0) @(posedge clk_i);
    repeat (Latency) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      RegMpt:    mpt = val;
      RegTptd:   tptd = val;
      RegReject: reject_thr = val[15:0];
      default:   dband = val[15:0];
    endcase
  endtask

  task automatic test_directed();
    send_reading(32'd0, 32'd0, 32'd1);
    send_reading(32'd100, 32'd100, 32'd1000);
    send_reading(32'd105, 32'd95, 32'd1000);
    send_reading(32'd120, 32'd130, 32'd0);
    send_reading(32'd200, 32'd150, 32'd5000);
    send_reading(32'd203, 32'd148, 32'd5000);
    send_reading(32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff);
    send_reading(32'h8000_0000, 32'h7fff_ffff, 32'd1);
    send_reading(32'hffff_ffff, 32'hffff_ffff, 32'd1);
    send_reading(32'd5, 32'd0, 32'd1);
    send_reading(32'd5, 32'd15, 32'd10);
    send_reading(32'd5, 32'd5, 32'd100);
  endtask

  task automatic test_config_extremes();
    write_reg(RegMpt, 32'hffff_ffff);
    write_reg(RegTptd, 32'hffff_ffff);
    write_reg(RegReject, 32'h0000_ffff);
    write_reg(RegDband, 32'd0);
    send_reading(32'd0, 32'd0, 32'd1);
    send_reading(32'd1000, 32'd2000, 32'd1);
    send_reading(32'h4000_0000, 32'hc000_0000, 32'd3);
    send_reading(32'h4000_1000, 32'hc000_0000, 32'd100);
    write_reg(RegMpt, 32'd0);
    write_reg(RegTptd, 32'd0);
    write_reg(RegReject, 32'd0);
    write_reg(RegDband, 32'h0000_ffff);
    send_reading(32'd70000, 32'd1, 32'd7);
    send_reading(32'd70001, 32'd2, 32'd7);
  endtask

  task automatic run_random(int n, int sidle, int rstall);
    logic [31:0] l, r, el;
    send_idle_pct  = sidle;
    recv_stall_pct = rstall;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) == 0) begin
        l = $urandom(); r = $urandom();
      end else begin
        l = prev_l + 32'($signed($urandom_range(200)) - 100);
        r = $urandom_range(3) == 0 ? l + 32'($signed($urandom_range(60)) - 30)
                                  : prev_r + 32'($signed($urandom_range(200)) - 100);
      end
      case ($urandom_range(3))
        0: el = $urandom();
        1: el = $urandom_range(3);
        default: el = $urandom_range(20000, 1000);
      endcase
      send_reading(l, r, el);
    end
  endtask

  task automatic test_random_settings();
    write_reg(RegMpt, MptReset);
    write_reg(RegTptd, TptdReset);
    write_reg(RegReject, RejectReset);
    write_reg(RegDband, DbandReset);
    run_random(250, 0, 0);
    write_reg(RegMpt, $urandom());
    write_reg(RegTptd, $urandom());
    write_reg(RegReject, $urandom_range(300));
    write_reg(RegDband, $urandom_range(40));
    run_random(250, 67, 0);
    write_reg(RegReject, 16'hffff);
    write_reg(RegDband, 16'd1);
    run_random(250, 0, 67);
    write_reg(RegMpt, $urandom());
    write_reg(RegTptd, $urandom_range(50000000));
    run_random(250, 29, 29);
  endtask

  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    fork
      begin
        hold_off = 1'b1;
        repeat (2000) @(posedge clk_i);
        hold_off = 1'b0;
      end
    join_none
    run_random(12, 0, 0);
    drain();
    run_random(10, 0, 0);
  endtask

  initial begin
    mpt = MptReset; tptd = TptdReset; reject_thr = RejectReset; dband = DbandReset;
    prev_l = '0; prev_r = '0; head = '0; primed = 1'b0; px = '0; py = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_config_extremes();
    test_random_settings();
    test_backpressure();
    drain();
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

@@ differential_drive_odometry.f @@
rtl/ddo_pkg.sv
rtl/differential_drive_odometry.sv
bench/differential_drive_odometry_tb.sv
